[sv/assert_macros.svh]
// Assertion macros used by the top level of the sliding window sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form with an explicit clock and active-low reset.
`define SWFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sliding window sender assertion failed");

// Short form for modules that use the house clock and reset names.
`define SWFR_ASSERT_CLK(lbl, prop) `SWFR_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

[sv/swfr_pkg.sv]
// Package with types, constants and codes of the sliding window sender.
package swfr_pkg;

    localparam int SEQ_W       = 4;
    localparam int SEQ_SPACE   = 1 << SEQ_W;
    localparam int DATA_BITS   = 32;
    localparam int WL_W        = 4;
    localparam int DT_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int MAX_WINDOW  = 8;
    localparam int DUP_MAX     = 7;
    localparam int WL_RESET    = 8;
    localparam int DT_RESET    = 3;
    localparam int FQ_DEPTH    = 4;
    localparam int FQ_AW       = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_AW       = $clog2(OQ_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DUP_THRESHOLD = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TIMER = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                 cmd;
        logic [DATA_BITS-1:0] data;
        logic [SEQ_W-1:0]     seq;
    } t_item;

    typedef struct packed {
        logic [WL_W-1:0] window_limit;
        logic [DT_W-1:0] dup_threshold;
    } t_cfg;

    typedef struct packed {
        logic                 accepted;
        logic                 tx_valid;
        logic [SEQ_W-1:0]     tx_seq;
        logic [DATA_BITS-1:0] tx_data;
        logic                 tx_is_retry;
        logic                 stop_valid;
        logic [SEQ_W-1:0]     stop_seq;
        logic                 start_valid;
        logic [SEQ_W-1:0]     start_seq;
        logic [SEQ_W-1:0]     window_base;
        logic [SEQ_W-1:0]     outstanding;
        logic                 window_full;
    } t_result;

endpackage

[sv/swfr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module swfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/swfr_front.sv]
// Front end: accepts input items, classifies them and queues them for the back end.
module swfr_front import swfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_cmd,
    input  logic [DATA_BITS-1:0] i_payload,
    input  logic [SEQ_W-1:0]     i_ack_num,
    input  logic                 i_ack_check_ok,
    input  logic [SEQ_W-1:0]     i_timer_seq,
    output logic                 o_valid,
    output t_item                o_item,
    input  logic                 i_take
);

    t_item            r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp, n_wp;
    logic [FQ_AW-1:0] r_rp, n_rp;
    logic [FQ_AW:0]   r_cnt, n_cnt;
    logic             push;
    t_item            cls;

    // An acknowledgement with a bad checksum is queued as no command and changes no window state.
    always_comb begin
        cls.data = i_payload;
        cls.seq  = '0;
        case (t_cmd'(i_cmd))
            CMD_SEND: begin
                cls.cmd = CMD_SEND;
            end
            CMD_ACK: begin
                cls.cmd = i_ack_check_ok ? CMD_ACK : CMD_NONE;
                cls.seq = i_ack_num;
            end
            CMD_TIMER: begin
                cls.cmd = CMD_TIMER;
                cls.seq = i_timer_seq;
            end
            default: begin
                cls.cmd = CMD_NONE;
            end
        endcase
    end

    assign o_full  = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign push    = i_push && !o_full;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_take ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (FQ_AW+1)'(push) - (FQ_AW+1)'(i_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

[sv/swfr_back.sv]
// Back end: window state, payload ring, result staging and the result queue.
module swfr_back import swfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_next, n_next;
    logic [SEQ_W-1:0] r_last, n_last;
    logic [DT_W-1:0]  r_dup, n_dup;

    logic [SEQ_W-1:0] pend, n_pend, gap;
    logic [WL_W-1:0]  lim;
    logic [DT_W-1:0]  thr;
    t_result          res;
    logic             use_ram;
    logic             ram_we;
    logic [DATA_BITS-1:0] ram_q;

    logic             r_b_valid;
    t_result          r_b_res;
    logic             r_b_ram;

    t_result          r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp, r_orp;
    logic [OQ_AW:0]   r_ocnt, n_ocnt, occ;
    logic             pop;
    t_result          entry;

    assign occ     = r_ocnt + (OQ_AW+1)'(r_b_valid);
    assign o_take  = i_valid && (occ < (OQ_AW+1)'(OQ_DEPTH));
    assign o_empty = (r_ocnt == '0);
    assign pop     = i_pop && !o_empty;

    always_comb begin
        pend    = r_next - r_base;
        lim     = (i_cfg.window_limit > WL_W'(MAX_WINDOW)) ? WL_W'(MAX_WINDOW)
                                                           : i_cfg.window_limit;
        thr     = (i_cfg.dup_threshold == '0) ? DT_W'(1) : i_cfg.dup_threshold;
        gap     = i_item.seq - r_base;
        res     = '0;
        use_ram = 1'b0;
        ram_we  = 1'b0;
        n_base  = r_base;
        n_next  = r_next;
        n_last  = r_last;
        n_dup   = r_dup;
        case (i_item.cmd)
            CMD_SEND: begin
                if (WL_W'(pend) < lim) begin
                    ram_we       = 1'b1;
                    res.accepted = 1'b1;
                    res.tx_valid = 1'b1;
                    res.tx_seq   = r_next;
                    res.tx_data  = i_item.data;
                    if (r_base == r_next) begin
                        res.start_valid = 1'b1;
                        res.start_seq   = r_base;
                    end
                    n_next = r_next + 1'b1;
                end
            end
            CMD_ACK: begin
                if (i_item.seq == r_last) begin
                    if (r_dup != DT_W'(DUP_MAX)) begin
                        n_dup = r_dup + 1'b1;
                    end
                end else begin
                    n_last = i_item.seq;
                    n_dup  = DT_W'(1);
                end
                if ((n_dup >= thr) && (gap < pend)) begin
                    use_ram         = 1'b1;
                    res.tx_valid    = 1'b1;
                    res.tx_is_retry = 1'b1;
                    res.tx_seq      = i_item.seq;
                    res.stop_valid  = 1'b1;
                    res.stop_seq    = i_item.seq;
                    res.start_valid = 1'b1;
                    res.start_seq   = i_item.seq;
                end
                if ((gap != '0) && (gap <= pend)) begin
                    res.stop_valid = 1'b1;
                    res.stop_seq   = r_base;
                    n_base         = i_item.seq;
                    if (i_item.seq != r_next) begin
                        res.start_valid = 1'b1;
                        res.start_seq   = i_item.seq;
                    end
                end
            end
            CMD_TIMER: begin
                if (gap < pend) begin
                    use_ram         = 1'b1;
                    res.tx_valid    = 1'b1;
                    res.tx_is_retry = 1'b1;
                    res.tx_seq      = i_item.seq;
                    res.stop_valid  = 1'b1;
                    res.stop_seq    = i_item.seq;
                    res.start_valid = 1'b1;
                    res.start_seq   = i_item.seq;
                end
            end
            default: begin
            end
        endcase
        n_pend          = n_next - n_base;
        res.window_base = n_base;
        res.outstanding = n_pend;
        res.window_full = (WL_W'(n_pend) >= lim);
    end

    swfr_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (SEQ_SPACE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (o_take && ram_we),
        .i_waddr (r_next),
        .i_wdata (i_item.data),
        .i_re    (o_take && use_ram),
        .i_raddr (i_item.seq),
        .o_rdata (ram_q)
    );

    always_comb begin
        entry = r_b_res;
        if (r_b_ram) begin
            entry.tx_data = ram_q;
        end
        n_ocnt = r_ocnt + (OQ_AW+1)'(r_b_valid) - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= SEQ_W'(1);
            r_next    <= SEQ_W'(1);
            r_last    <= '0;
            r_dup     <= '0;
            r_b_valid <= 1'b0;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ocnt    <= '0;
        end else begin
            if (o_take) begin
                r_base <= n_base;
                r_next <= n_next;
                r_last <= n_last;
                r_dup  <= n_dup;
            end
            r_b_valid <= o_take;
            if (r_b_valid) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_b_res <= res;
            r_b_ram <= use_ram;
        end
        if (r_b_valid) begin
            r_oq[r_owp] <= entry;
        end
    end

    assign o_result = r_oq[r_orp];

endmodule

[sv/sliding_window_sender_fast_retx_core.sv]
// Top level of the sliding window sender with fast retransmission.
// Each result passes through the back-end staging register and the result queue to the ports.
// Throughput: one item per cycle unless the result queue is full, set by the back-end window
// state update and the one read port of the payload ring.
// Reset is synchronous and active low: queues empty, base and next sequence 1, registers
// at their defaults; the payload ring is not cleared.
`include "assert_macros.svh"

module sliding_window_sender_fast_retx_core import swfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_cmd,
    input  logic [DATA_BITS-1:0]  i_payload,
    input  logic [SEQ_W-1:0]      i_ack_num,
    input  logic                  i_ack_check_ok,
    input  logic [SEQ_W-1:0]      i_timer_seq,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic                  o_accepted,
    output logic                  o_tx_valid,
    output logic [SEQ_W-1:0]      o_tx_seq,
    output logic [DATA_BITS-1:0]  o_tx_data,
    output logic                  o_tx_is_retry,
    output logic                  o_stop_valid,
    output logic [SEQ_W-1:0]      o_stop_seq,
    output logic                  o_start_valid,
    output logic [SEQ_W-1:0]      o_start_seq,
    output logic [SEQ_W-1:0]      o_window_base,
    output logic [SEQ_W-1:0]      o_outstanding,
    output logic                  o_window_full,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [WL_W-1:0] r_window_limit;
    logic [DT_W-1:0] r_dup_threshold;
    t_cfg            cfg;
    logic            q_valid;
    t_item           q_item;
    logic            take;
    t_result         result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit  <= WL_W'(WL_RESET);
            r_dup_threshold <= DT_W'(DT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_LIMIT: begin
                    r_window_limit <= i_cfg_data[WL_W-1:0];
                end
                REG_DUP_THRESHOLD: begin
                    r_dup_threshold <= i_cfg_data[DT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.window_limit  = r_window_limit;
    assign cfg.dup_threshold = r_dup_threshold;

    swfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_cmd          (i_cmd),
        .i_payload      (i_payload),
        .i_ack_num      (i_ack_num),
        .i_ack_check_ok (i_ack_check_ok),
        .i_timer_seq    (i_timer_seq),
        .o_valid        (q_valid),
        .o_item         (q_item),
        .i_take         (take)
    );

    swfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_take   (take),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (result)
    );

    assign o_accepted    = result.accepted;
    assign o_tx_valid    = result.tx_valid;
    assign o_tx_seq      = result.tx_seq;
    assign o_tx_data     = result.tx_data;
    assign o_tx_is_retry = result.tx_is_retry;
    assign o_stop_valid  = result.stop_valid;
    assign o_stop_seq    = result.stop_seq;
    assign o_start_valid = result.start_valid;
    assign o_start_seq   = result.start_seq;
    assign o_window_base = result.window_base;
    assign o_outstanding = result.outstanding;
    assign o_window_full = result.window_full;

    `SWFR_ASSERT_CLK(a_retry_has_tx, !o_empty && o_tx_is_retry |-> o_tx_valid)
    `SWFR_ASSERT_CLK(a_accept_fresh, !o_empty && o_accepted |-> o_tx_valid && !o_tx_is_retry)
    `SWFR_ASSERT_CLK(a_window_bound, !o_empty |-> o_outstanding <= SEQ_W'(MAX_WINDOW))

endmodule

[bench/tb_sliding_window_sender_fast_retx_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sliding window sender with fast retransmission.
module tb_sliding_window_sender_fast_retx_core;
    import swfr_pkg::*;

    typedef struct packed {
        t_cmd                 cmd;
        logic [DATA_BITS-1:0] payload;
        logic [SEQ_W-1:0]     ack_num;
        logic                 ack_ok;
        logic [SEQ_W-1:0]     timer_seq;
    } t_event;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    localparam int NUM_PHASES   = 8;
    localparam int PRESS_PHASE  = 4;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_EVENTS = 90;
    localparam int GEN          = 0;
    localparam int CHK          = 1;

    localparam int    PH_WL[NUM_PHASES]   = '{8, 1, 4, 0, 15, 9, 6, 8};
    localparam int    PH_DT[NUM_PHASES]   = '{3, 1, 7, 0, 2, 5, 1, 4};
    localparam t_idle PH_IDLE[NUM_PHASES] = '{IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
                                              IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_push         = 1'b0;
    logic                  o_full;
    logic [1:0]            i_cmd          = '0;
    logic [DATA_BITS-1:0]  i_payload      = '0;
    logic [SEQ_W-1:0]      i_ack_num      = '0;
    logic                  i_ack_check_ok = 1'b0;
    logic [SEQ_W-1:0]      i_timer_seq    = '0;
    logic                  o_empty;
    logic                  i_pop          = 1'b0;
    logic                  o_accepted;
    logic                  o_tx_valid;
    logic [SEQ_W-1:0]      o_tx_seq;
    logic [DATA_BITS-1:0]  o_tx_data;
    logic                  o_tx_is_retry;
    logic                  o_stop_valid;
    logic [SEQ_W-1:0]      o_stop_seq;
    logic                  o_start_valid;
    logic [SEQ_W-1:0]      o_start_seq;
    logic [SEQ_W-1:0]      o_window_base;
    logic [SEQ_W-1:0]      o_outstanding;
    logic                  o_window_full;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Two copies of the window model: one runs ahead while events are generated,
    // the other advances on each accepted transfer.
    logic [SEQ_W-1:0]     base_seq[2];
    logic [SEQ_W-1:0]     next_seq[2];
    logic [SEQ_W-1:0]     last_ack[2];
    logic [DT_W-1:0]      dup_cnt[2];
    logic [WL_W-1:0]      win_limit[2];
    logic [DT_W-1:0]      dup_thr[2];
    logic [DATA_BITS-1:0] ring[2][SEQ_SPACE];

    t_event  pending_events[$];
    t_result expected_reports[$];
    t_event  on_wire;
    t_idle   idle_mode = IDLE_NONE;
    int      bad_count = 0;
    int      hold_left = 0;
    bit      hold_kick = 1'b0;
    bit      hold_seen = 1'b0;

    sliding_window_sender_fast_retx_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_cmd          (i_cmd),
        .i_payload      (i_payload),
        .i_ack_num      (i_ack_num),
        .i_ack_check_ok (i_ack_check_ok),
        .i_timer_seq    (i_timer_seq),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_accepted     (o_accepted),
        .o_tx_valid     (o_tx_valid),
        .o_tx_seq       (o_tx_seq),
        .o_tx_data      (o_tx_data),
        .o_tx_is_retry  (o_tx_is_retry),
        .o_stop_valid   (o_stop_valid),
        .o_stop_seq     (o_stop_seq),
        .o_start_valid  (o_start_valid),
        .o_start_seq    (o_start_seq),
        .o_window_base  (o_window_base),
        .o_outstanding  (o_outstanding),
        .o_window_full  (o_window_full),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void reset_window(input int m);
        base_seq[m]  = SEQ_W'(1);
        next_seq[m]  = SEQ_W'(1);
        last_ack[m]  = '0;
        dup_cnt[m]   = '0;
        win_limit[m] = WL_W'(WL_RESET);
        dup_thr[m]   = DT_W'(DT_RESET);
    endfunction

    function automatic t_result window_step(input int m, input t_event ev);
        t_result          r;
        logic [SEQ_W-1:0] pend;
        logic [SEQ_W-1:0] lim;
        logic [SEQ_W-1:0] gap;
        logic [SEQ_W-1:0] s;
        logic [DT_W-1:0]  thr;
        r    = '0;
        pend = next_seq[m] - base_seq[m];
        lim  = (win_limit[m] > MAX_WINDOW) ? SEQ_W'(MAX_WINDOW) : win_limit[m];
        case (ev.cmd)
            CMD_SEND: begin
                if (pend < lim) begin
                    s           = next_seq[m];
                    ring[m][s]  = ev.payload;
                    r.accepted  = 1'b1;
                    r.tx_valid  = 1'b1;
                    r.tx_seq    = s;
                    r.tx_data   = ev.payload;
                    if (base_seq[m] == next_seq[m]) begin
                        r.start_valid = 1'b1;
                        r.start_seq   = base_seq[m];
                    end
                    next_seq[m] = s + 1'b1;
                end
            end
            CMD_ACK: begin
                if (ev.ack_ok) begin
                    thr = (dup_thr[m] == 0) ? DT_W'(1) : dup_thr[m];
                    if (ev.ack_num == last_ack[m]) begin
                        if (dup_cnt[m] < DUP_MAX) begin
                            dup_cnt[m] = dup_cnt[m] + 1'b1;
                        end
                    end else begin
                        last_ack[m] = ev.ack_num;
                        dup_cnt[m]  = DT_W'(1);
                    end
                    gap = last_ack[m] - base_seq[m];
                    if (dup_cnt[m] >= thr && gap < pend) begin
                        r.tx_valid    = 1'b1;
                        r.tx_is_retry = 1'b1;
                        r.tx_seq      = last_ack[m];
                        r.tx_data     = ring[m][last_ack[m]];
                        r.stop_valid  = 1'b1;
                        r.stop_seq    = last_ack[m];
                        r.start_valid = 1'b1;
                        r.start_seq   = last_ack[m];
                    end
                    gap = ev.ack_num - base_seq[m];
                    if (gap != 0 && gap <= pend) begin
                        r.stop_valid = 1'b1;
                        r.stop_seq   = base_seq[m];
                        base_seq[m]  = ev.ack_num;
                        if (base_seq[m] != next_seq[m]) begin
                            r.start_valid = 1'b1;
                            r.start_seq   = base_seq[m];
                        end
                    end
                end
            end
            CMD_TIMER: begin
                s   = ev.timer_seq;
                gap = s - base_seq[m];
                if (gap < pend) begin
                    r.tx_valid    = 1'b1;
                    r.tx_is_retry = 1'b1;
                    r.tx_seq      = s;
                    r.tx_data     = ring[m][s];
                    r.stop_valid  = 1'b1;
                    r.stop_seq    = s;
                    r.start_valid = 1'b1;
                    r.start_seq   = s;
                end
            end
            default: begin
            end
        endcase
        pend          = next_seq[m] - base_seq[m];
        r.window_base = base_seq[m];
        r.outstanding = pend;
        r.window_full = (pend >= lim);
        return r;
    endfunction

    function automatic t_event mk(input t_cmd c, input logic [DATA_BITS-1:0] pl,
                                  input logic [SEQ_W-1:0] an, input logic ok,
                                  input logic [SEQ_W-1:0] ts);
        t_event ev;
        ev.cmd       = c;
        ev.payload   = pl;
        ev.ack_num   = an;
        ev.ack_ok    = ok;
        ev.timer_seq = ts;
        return ev;
    endfunction

    function automatic void queue_event(input t_event ev);
        void'(window_step(GEN, ev));
        pending_events.insert(pending_events.size(), ev);
    endfunction

    function automatic void add_random(input int n);
        t_event           ev;
        logic [SEQ_W-1:0] pend;
        int               k;
        int               pick;
        int               reps;
        for (k = 0; k < n; k++) begin
            ev   = mk(t_cmd'($urandom_range(3)), $urandom, SEQ_W'($urandom_range(15)),
                      1'($urandom_range(1)), SEQ_W'($urandom_range(15)));
            pend = next_seq[GEN] - base_seq[GEN];
            pick = $urandom_range(99);
            if (pick < 40) begin
                ev.cmd = CMD_SEND;
            end else if (pick < 72 && pend != 0) begin
                ev.cmd     = CMD_ACK;
                ev.ack_ok  = 1'b1;
                ev.ack_num = base_seq[GEN] + SEQ_W'($urandom_range(pend, 1));
            end else if (pick < 80 && pend != 0) begin
                ev.cmd     = CMD_ACK;
                ev.ack_ok  = 1'b1;
                ev.ack_num = base_seq[GEN];
                reps       = $urandom_range(8, 1);
                repeat (reps) queue_event(ev);
            end else if (pick < 90 && pend != 0) begin
                ev.cmd       = CMD_TIMER;
                ev.timer_seq = base_seq[GEN] + SEQ_W'($urandom_range(pend - 1, 0));
            end
            queue_event(ev);
        end
    endfunction

    function automatic void cmp(input string fname, input logic [DATA_BITS-1:0] want,
                                input logic [DATA_BITS-1:0] got);
        if (want !== got) begin
            bad_count++;
            if (bad_count <= 10) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, fname, want, got);
            end
        end
    endfunction

    function automatic int idle_pct(input bit recv_side);
        if (idle_mode == IDLE_BOTH) begin
            return 6;
        end else if (idle_mode == (recv_side ? IDLE_RECV : IDLE_SEND)) begin
            return 74;
        end
        return 0;
    endfunction

    task automatic wait_drained();
        while (pending_events.size() != 0 || i_push || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_config(input int wl, input int dt);
        int m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WINDOW_LIMIT;
        i_cfg_data <= CFG_DATA_W'(wl);
        @(posedge i_clk);
        i_cfg_idx  <= REG_DUP_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(dt);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        for (m = 0; m < 2; m++) begin
            win_limit[m] = WL_W'(wl);
            dup_thr[m]   = DT_W'(dt);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                expected_reports.insert(expected_reports.size(), window_step(CHK, on_wire));
            end
            if (!i_push || !o_full) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    on_wire        = pending_events[0];
                    pending_events.delete(0);
                    i_push         <= 1'b1;
                    i_cmd          <= on_wire.cmd;
                    i_payload      <= on_wire.payload;
                    i_ack_num      <= on_wire.ack_num;
                    i_ack_check_ok <= on_wire.ack_ok;
                    i_timer_seq    <= on_wire.timer_seq;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_kick;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_reports.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display("%0t: result transfer with nothing expected", $realtime);
                    end
                end else begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    cmp("accepted", DATA_BITS'(want.accepted), DATA_BITS'(o_accepted));
                    cmp("tx_valid", DATA_BITS'(want.tx_valid), DATA_BITS'(o_tx_valid));
                    cmp("tx_seq", DATA_BITS'(want.tx_seq), DATA_BITS'(o_tx_seq));
                    cmp("tx_data", want.tx_data, o_tx_data);
                    cmp("tx_is_retry", DATA_BITS'(want.tx_is_retry), DATA_BITS'(o_tx_is_retry));
                    cmp("stop_valid", DATA_BITS'(want.stop_valid), DATA_BITS'(o_stop_valid));
                    cmp("stop_seq", DATA_BITS'(want.stop_seq), DATA_BITS'(o_stop_seq));
                    cmp("start_valid", DATA_BITS'(want.start_valid), DATA_BITS'(o_start_valid));
                    cmp("start_seq", DATA_BITS'(want.start_seq), DATA_BITS'(o_start_seq));
                    cmp("window_base", DATA_BITS'(want.window_base), DATA_BITS'(o_window_base));
                    cmp("outstanding", DATA_BITS'(want.outstanding), DATA_BITS'(o_outstanding));
                    cmp("window_full", DATA_BITS'(want.window_full), DATA_BITS'(o_window_full));
                end
            end
            i_pop <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    initial begin
        int p;
        reset_window(GEN);
        reset_window(CHK);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the window to eight, then a refused send.
        queue_event(mk(CMD_SEND, 32'h0000_0000, 4'd0, 1'b0, 4'd0));
        queue_event(mk(CMD_SEND, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd15));
        queue_event(mk(CMD_SEND, 32'hA5A5_A5A5, 4'd0, 1'b0, 4'd0));
        queue_event(mk(CMD_SEND, 32'h5A5A_5A5A, 4'd0, 1'b0, 4'd0));
        repeat (5) queue_event(mk(CMD_SEND, $urandom, 4'd0, 1'b0, 4'd0));
        queue_event(mk(CMD_ACK, '0, 4'd3, 1'b0, 4'd0));
        queue_event(mk(CMD_TIMER, '0, 4'd0, 1'b0, 4'd0));
        queue_event(mk(CMD_TIMER, '0, 4'd0, 1'b0, 4'd3));
        repeat (3) queue_event(mk(CMD_ACK, '0, 4'd1, 1'b1, 4'd0));
        queue_event(mk(CMD_ACK, '0, 4'd3, 1'b1, 4'd0));
        queue_event(mk(CMD_ACK, '0, 4'd9, 1'b1, 4'd0));
        queue_event(mk(CMD_TIMER, '0, 4'd0, 1'b0, 4'd9));
        queue_event(mk(CMD_NONE, $urandom, 4'd5, 1'b1, 4'd5));
        queue_event(mk(CMD_ACK, '0, 4'd12, 1'b1, 4'd0));
        queue_event(mk(CMD_SEND, $urandom, 4'd0, 1'b0, 4'd0));

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_config(PH_WL[p], PH_DT[p]);
            idle_mode <= PH_IDLE[p];
            if (p == PRESS_PHASE) begin
                hold_kick <= ~hold_kick;
            end
            add_random(PHASE_EVENTS / 2);
            if (p == PRESS_PHASE) begin
                wait_drained();
            end
            add_random(PHASE_EVENTS - PHASE_EVENTS / 2);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        bad_count += expected_reports.size();
        if (bad_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
